FILE: rtl/arw_pkg.sv
// Shared types and codes for the ARQ receive window reassembly block.
`default_nettype none
package arw_pkg;
	typedef enum logic [2:0] {
		RK_ACK     = 3'd0,
		RK_DELIVER = 3'd1,
		RK_DUP     = 3'd2,
		RK_OOW     = 3'd3,
		RK_IGNORED = 3'd4
	} result_kind_t;

	localparam logic [1:0] KIND_PUSH = 2'd0;

	localparam logic REG_CONV = 1'b0;
	localparam logic REG_WND  = 1'b1;

	typedef struct packed {
		logic shift;
		logic wr_en;
	} cell_ctl_t;
endpackage
`default_nettype wire

FILE: rtl/arw_cell.sv
// One window slot cell: holds a segment and takes its neighbor's on a shift.
`default_nettype none
module arw_cell #(
	parameter int HANDLE_BITS = 10
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  arw_pkg::cell_ctl_t     ctl,
	input  wire [7:0]              wr_frag,
	input  wire [HANDLE_BITS-1:0]  wr_handle,
	input  wire                    nxt_filled,
	input  wire [7:0]              nxt_frag,
	input  wire [HANDLE_BITS-1:0]  nxt_handle,
	output logic                   filled,
	output logic [7:0]             frag,
	output logic [HANDLE_BITS-1:0] handle
);
	import arw_pkg::*;

	logic                   filled_q;
	logic [7:0]             frag_q;
	logic [HANDLE_BITS-1:0] handle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			filled_q <= 1'b0;
		end else if (ctl.shift) begin
			filled_q <= nxt_filled;
		end else if (ctl.wr_en) begin
			filled_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.shift) begin
			frag_q   <= nxt_frag;
			handle_q <= nxt_handle;
		end else if (ctl.wr_en) begin
			frag_q   <= wr_frag;
			handle_q <= wr_handle;
		end
	end

	assign filled = filled_q;
	assign frag   = frag_q;
	assign handle = handle_q;
endmodule
`default_nettype wire

FILE: rtl/arq_receive_window_reassembly_top.sv
// Top level of the ARQ receive window: classify, store and deliver segments.
// The first result strobe is registered out of the evaluate state, entered from idle when start is taken.
// A new segment is taken only in the idle state, after its evaluation and any delivery run;
// the delivery run shifts the slot chain one cell per cycle.
// Reset clears every slot cell's fill flag, the next expected number and the output registers at once,
// and sets the window register to 32. The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none
module arq_receive_window_reassembly_top #(
	parameter int WINDOW_SLOTS = 32,
	parameter int HANDLE_BITS  = 10
) (
	input  wire                    clk,
	input  wire                    arst_n,
	input  wire                    psel,
	input  wire                    penable,
	input  wire                    pwrite,
	input  wire [2:0]              paddr,
	input  wire [31:0]             pwdata,
	output logic [31:0]            prdata,
	output logic                   pready,
	input  wire                    start,
	output logic                   busy,
	input  wire [1:0]              kind,
	input  wire [31:0]             seq_num,
	input  wire [7:0]              fragment_count,
	input  wire [31:0]             timestamp,
	input  wire [HANDLE_BITS-1:0]  payload_handle,
	input  wire [31:0]             send_una,
	output logic                   strobe,
	output logic [2:0]             result_kind,
	output logic [31:0]            out_conversation,
	output logic [31:0]            out_seq,
	output logic [31:0]            out_timestamp,
	output logic [5:0]             out_window,
	output logic [31:0]            out_una,
	output logic [HANDLE_BITS-1:0] out_handle,
	output logic [7:0]             out_fragment,
	output logic                   last
);
	import arw_pkg::*;

	localparam int OW = (WINDOW_SLOTS > 1) ? $clog2(WINDOW_SLOTS) : 1;
	localparam logic [5:0] SLOTS6 = 6'(WINDOW_SLOTS);

	typedef enum logic [1:0] {ST_IDLE, ST_EVAL, ST_DELIVER} state_t;

	state_t state_q;
	logic [31:0] conv_q;
	logic [5:0]  rwnd_q;
	logic [31:0] ne_q;

	logic [1:0]             kind_s1;
	logic [31:0]            seq_s1;
	logic [7:0]             frag_s1;
	logic [31:0]            ts_s1;
	logic [HANDLE_BITS-1:0] handle_s1;
	logic [31:0]            una_s1;

	logic                   strobe_q;
	logic [2:0]             rk_q;
	logic [31:0]            conv_out_q, seq_out_q, ts_out_q, una_out_q;
	logic [5:0]             wnd_out_q;
	logic [HANDLE_BITS-1:0] handle_out_q;
	logic [7:0]             frag_out_q;
	logic                   last_q;

	logic                   filled_w [WINDOW_SLOTS+1];
	logic [7:0]             frag_w   [WINDOW_SLOTS+1];
	logic [HANDLE_BITS-1:0] hnd_w    [WINDOW_SLOTS+1];

	logic        cfg_wr;
	logic [5:0]  wnd;
	logic [31:0] diff;
	logic [OW-1:0] off;
	logic        is_push, is_dup, is_oow, do_store, do_shift;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_WND) ? {26'd0, rwnd_q} : conv_q;

	assign wnd      = (rwnd_q > SLOTS6) ? SLOTS6 : rwnd_q;
	assign diff     = seq_s1 - ne_q;
	assign off      = diff[OW-1:0];
	assign is_push  = (kind_s1 == KIND_PUSH);
	assign is_dup   = seq_s1 < ne_q;
	assign is_oow   = {1'b0, seq_s1} >= ({1'b0, ne_q} + {27'd0, wnd});
	assign do_store = (state_q == ST_EVAL) && is_push && !is_dup && !is_oow;
	assign do_shift = (state_q == ST_DELIVER);
	assign busy     = (state_q != ST_IDLE);

	assign filled_w[WINDOW_SLOTS] = 1'b0;
	assign frag_w[WINDOW_SLOTS]   = 8'd0;
	assign hnd_w[WINDOW_SLOTS]    = '0;

	for (genvar i = 0; i < WINDOW_SLOTS; i++) begin : g_cell
		cell_ctl_t ctl;
		assign ctl.shift = do_shift;
		// an occupied slot keeps its segment; the new one is dropped
		assign ctl.wr_en = do_store && (off == OW'(i)) && !filled_w[i];
		arw_cell #(.HANDLE_BITS(HANDLE_BITS)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctl        (ctl),
			.wr_frag    (frag_s1),
			.wr_handle  (handle_s1),
			.nxt_filled (filled_w[i+1]),
			.nxt_frag   (frag_w[i+1]),
			.nxt_handle (hnd_w[i+1]),
			.filled     (filled_w[i]),
			.frag       (frag_w[i]),
			.handle     (hnd_w[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_q <= 32'd0;
			rwnd_q <= 6'd32;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_CONV) conv_q <= pwdata;
			else rwnd_q <= pwdata[5:0];
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			kind_s1   <= kind;
			seq_s1    <= seq_num;
			frag_s1   <= fragment_count;
			ts_s1     <= timestamp;
			handle_s1 <= payload_handle;
			una_s1    <= send_una;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			ne_q         <= 32'd0;
			strobe_q     <= 1'b0;
			rk_q         <= RK_IGNORED;
			conv_out_q   <= 32'd0;
			seq_out_q    <= 32'd0;
			ts_out_q     <= 32'd0;
			una_out_q    <= 32'd0;
			wnd_out_q    <= 6'd0;
			handle_out_q <= '0;
			frag_out_q   <= 8'd0;
			last_q       <= 1'b0;
		end else begin
			strobe_q     <= 1'b0;
			conv_out_q   <= 32'd0;
			seq_out_q    <= 32'd0;
			ts_out_q     <= 32'd0;
			una_out_q    <= 32'd0;
			wnd_out_q    <= 6'd0;
			handle_out_q <= '0;
			frag_out_q   <= 8'd0;
			last_q       <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					strobe_q <= 1'b1;
					last_q   <= 1'b1;
					state_q  <= ST_IDLE;
					if (!is_push) begin
						rk_q <= RK_IGNORED;
					end else if (is_dup) begin
						rk_q      <= RK_DUP;
						seq_out_q <= seq_s1;
					end else if (is_oow) begin
						rk_q      <= RK_OOW;
						seq_out_q <= seq_s1;
					end else begin
						rk_q       <= RK_ACK;
						conv_out_q <= conv_q;
						seq_out_q  <= seq_s1;
						ts_out_q   <= ts_s1;
						wnd_out_q  <= wnd;
						una_out_q  <= una_s1;
						// head cell is empty at idle, so a run starts only here
						if (diff == 32'd0) begin
							last_q  <= 1'b0;
							state_q <= ST_DELIVER;
						end
					end
				end
				ST_DELIVER: begin
					strobe_q     <= 1'b1;
					rk_q         <= RK_DELIVER;
					seq_out_q    <= ne_q;
					handle_out_q <= hnd_w[0];
					frag_out_q   <= frag_w[0];
					ne_q         <= ne_q + 32'd1;
					if (!filled_w[1]) begin
						last_q  <= 1'b1;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign strobe           = strobe_q;
	assign result_kind      = rk_q;
	assign out_conversation = conv_out_q;
	assign out_seq          = seq_out_q;
	assign out_timestamp    = ts_out_q;
	assign out_window       = wnd_out_q;
	assign out_una          = una_out_q;
	assign out_handle       = handle_out_q;
	assign out_fragment     = frag_out_q;
	assign last             = last_q;
endmodule
`default_nettype wire
